>>> rtl/lhs_pkg.sv
// Shared constants, types and table builder for the local Hurst slope block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package lhs_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int FRAC_BITS  = 10;

  // range of four samples needs one bit more than a sample
  localparam int RANGE_W   = PIXEL_BITS + 1;
  localparam int EXP_W     = $clog2(RANGE_W);
  localparam int LOG_W     = EXP_W + FRAC_BITS;
  localparam int TBL_DEPTH = 2 ** FRAC_BITS;

  localparam int SLOPE_W   = 17;
  localparam int SLOPE_MAX = 65535;
  localparam int SLOPE_MIN = -65536;

  typedef logic [FRAC_BITS-1:0] log_tbl_t [TBL_DEPTH];

  // floor(2^F * log2(1 + k/2^F)) by repeated squaring in Q2.62, truncating
  function automatic logic [FRAC_BITS-1:0] frac_log2(input logic [FRAC_BITS-1:0] k);
    logic [63:0]          y;
    logic [127:0]         p;
    logic [FRAC_BITS-1:0] res;
    y   = 64'({1'b1, k}) << (62 - FRAC_BITS);
    res = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      p   = {64'd0, y} * {64'd0, y};
      y   = p[125:62];
      res = {res[FRAC_BITS-2:0], 1'b0};
      if (y[63]) begin
        res[0] = 1'b1;
        y      = y >> 1;
      end
    end
    return res;
  endfunction

  function automatic log_tbl_t build_log_tbl();
    log_tbl_t tbl;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      tbl[i] = frac_log2(FRAC_BITS'(i));
    end
    return tbl;
  endfunction

endpackage

>>> rtl/lhs_range4.sv
// Range (max minus min) of four signed samples, combinational.
// Depends on lhs_pkg for sample and range widths.
`timescale 1ns / 1ps

module lhs_range4 (
  input  logic signed [lhs_pkg::PIXEL_BITS-1:0] a_i,
  input  logic signed [lhs_pkg::PIXEL_BITS-1:0] b_i,
  input  logic signed [lhs_pkg::PIXEL_BITS-1:0] c_i,
  input  logic signed [lhs_pkg::PIXEL_BITS-1:0] d_i,
  output logic        [lhs_pkg::RANGE_W-1:0]    range_o
);

  logic signed [lhs_pkg::PIXEL_BITS-1:0] hi_ab, hi_cd, lo_ab, lo_cd, hi, lo;
  logic signed [lhs_pkg::RANGE_W-1:0]    diff;

  always_comb begin
    hi_ab = (a_i > b_i) ? a_i : b_i;
    lo_ab = (a_i > b_i) ? b_i : a_i;
    hi_cd = (c_i > d_i) ? c_i : d_i;
    lo_cd = (c_i > d_i) ? d_i : c_i;
    hi    = (hi_ab > hi_cd) ? hi_ab : hi_cd;
    lo    = (lo_ab < lo_cd) ? lo_ab : lo_cd;
    diff  = {hi[lhs_pkg::PIXEL_BITS-1], hi} - {lo[lhs_pkg::PIXEL_BITS-1], lo};
  end

  // hi >= lo, so the difference is never negative
  assign range_o = $unsigned(diff);

endmodule

>>> rtl/lhs_lead_one.sv
// Leading-one index and the fraction bits below it for one range value.
// Depends on lhs_pkg for widths.
`timescale 1ns / 1ps

module lhs_lead_one (
  input  logic [lhs_pkg::RANGE_W-1:0]   range_i,
  output logic [lhs_pkg::EXP_W-1:0]     exp_o,
  output logic [lhs_pkg::FRAC_BITS-1:0] frac_o,
  output logic                          zero_o
);

  localparam int NW = lhs_pkg::RANGE_W + lhs_pkg::FRAC_BITS;

  logic [lhs_pkg::EXP_W-1:0] sh;
  logic [NW-1:0]             norm;

  always_comb begin
    exp_o = '0;
    for (int i = 0; i < lhs_pkg::RANGE_W; i++) begin
      if (range_i[i]) begin
        exp_o = lhs_pkg::EXP_W'(i);
      end
    end
  end

  // put the leading one at the top; bits below it are the mantissa, zero-filled
  always_comb begin
    sh     = lhs_pkg::EXP_W'(lhs_pkg::RANGE_W - 1) - exp_o;
    norm   = {range_i, lhs_pkg::FRAC_BITS'(0)} << sh;
    frac_o = norm[NW-2 -: lhs_pkg::FRAC_BITS];
  end

  assign zero_o = (range_i == '0);

endmodule

>>> rtl/lhs_log_rom.sv
// Two-port read-only table of fractional log2 values, registered read data.
// Contents are built at elaboration by lhs_pkg::build_log_tbl.
`timescale 1ns / 1ps

module lhs_log_rom (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [lhs_pkg::FRAC_BITS-1:0] addr_a_i,
  input  logic [lhs_pkg::FRAC_BITS-1:0] addr_b_i,
  output logic [lhs_pkg::FRAC_BITS-1:0] data_a_o,
  output logic [lhs_pkg::FRAC_BITS-1:0] data_b_o
);

  localparam lhs_pkg::log_tbl_t LogTbl = lhs_pkg::build_log_tbl();

  logic [lhs_pkg::FRAC_BITS-1:0] data_a_q, data_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= LogTbl[addr_a_i];
      data_b_q <= LogTbl[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

>>> rtl/local_hurst_slope_3x3.sv
// Pipeline: input reg, range reg, log table read, result reg; out_valid_o is the
// valid bit of the result reg.
// Throughput: one transaction per cycle while out_stall_i is low; each stage advances
// when it is empty or its successor advances, so bubbles collapse under output stall.
// Reset: rst_ni async, active low, clears all stage valid bits; data regs not reset.
// Depends on lhs_pkg, lhs_range4, lhs_lead_one, lhs_log_rom.
`timescale 1ns / 1ps

module local_hurst_slope_3x3 (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [lhs_pkg::PIXEL_BITS-1:0] north_px_i,
  input  logic signed [lhs_pkg::PIXEL_BITS-1:0] south_px_i,
  input  logic signed [lhs_pkg::PIXEL_BITS-1:0] west_px_i,
  input  logic signed [lhs_pkg::PIXEL_BITS-1:0] east_px_i,
  input  logic signed [lhs_pkg::PIXEL_BITS-1:0] northwest_px_i,
  input  logic signed [lhs_pkg::PIXEL_BITS-1:0] northeast_px_i,
  input  logic signed [lhs_pkg::PIXEL_BITS-1:0] southwest_px_i,
  input  logic signed [lhs_pkg::PIXEL_BITS-1:0] southeast_px_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [lhs_pkg::SLOPE_W-1:0]    slope_o,
  output logic                                  undefined_o
);

  localparam int PW = lhs_pkg::PIXEL_BITS;
  localparam int AW = lhs_pkg::LOG_W + 2;
  localparam int CW = ((AW > lhs_pkg::SLOPE_W) ? AW : lhs_pkg::SLOPE_W) + 1;

  // stage enables, back to front
  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: input register
  logic signed [PW-1:0] n_q, s_q, w_q, e_q, nw_q, ne_q, sw_q, se_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      n_q  <= north_px_i;
      s_q  <= south_px_i;
      w_q  <= west_px_i;
      e_q  <= east_px_i;
      nw_q <= northwest_px_i;
      ne_q <= northeast_px_i;
      sw_q <= southwest_px_i;
      se_q <= southeast_px_i;
    end
  end

  // stage 2: axial and diagonal ranges
  logic [lhs_pkg::RANGE_W-1:0] r1_d, r2_d, r1_q, r2_q;

  lhs_range4 u_rng_axial (
    .a_i(n_q), .b_i(s_q), .c_i(w_q), .d_i(e_q), .range_o(r1_d)
  );

  lhs_range4 u_rng_diag (
    .a_i(nw_q), .b_i(ne_q), .c_i(sw_q), .d_i(se_q), .range_o(r2_d)
  );

  always_ff @(posedge clk_i) begin
    if (en2) begin
      r1_q <= r1_d;
      r2_q <= r2_d;
    end
  end

  // stage 3: exponent and table lookup of mantissa
  logic [lhs_pkg::EXP_W-1:0]     x1_d, x2_d, x1_q, x2_q;
  logic [lhs_pkg::FRAC_BITS-1:0] k1, k2, t1, t2;
  logic                          z1_d, z2_d, z1_q, z2_q;

  lhs_lead_one u_lead_axial (
    .range_i(r1_q), .exp_o(x1_d), .frac_o(k1), .zero_o(z1_d)
  );

  lhs_lead_one u_lead_diag (
    .range_i(r2_q), .exp_o(x2_d), .frac_o(k2), .zero_o(z2_d)
  );

  lhs_log_rom u_rom (
    .clk_i    (clk_i),
    .en_i     (en3),
    .addr_a_i (k1),
    .addr_b_i (k2),
    .data_a_o (t1),
    .data_b_o (t2)
  );

  always_ff @(posedge clk_i) begin
    if (en3) begin
      x1_q <= x1_d;
      x2_q <= x2_d;
      z1_q <= z1_d;
      z2_q <= z2_d;
    end
  end

  // stage 4: slope = 2*log2(r2) - log2(r1), zero terms dropped
  logic [lhs_pkg::LOG_W-1:0]          l1, l2;
  logic signed [AW-1:0]               a2, a1, diff;
  logic signed [CW-1:0]               ext;
  logic signed [lhs_pkg::SLOPE_W-1:0] slope_d, slope_q;
  logic                               undef_d, undef_q;

  always_comb begin
    l1      = {x1_q, t1};
    l2      = {x2_q, t2};
    a2      = z2_q ? '0 : $signed({1'b0, l2, 1'b0});
    a1      = z1_q ? '0 : $signed({2'b00, l1});
    undef_d = !z1_q && z2_q;
    diff    = undef_d ? '0 : (a2 - a1);
    ext     = {{(CW - AW){diff[AW-1]}}, diff};
    if (ext > $signed(CW'(lhs_pkg::SLOPE_MAX))) begin
      slope_d = lhs_pkg::SLOPE_W'(lhs_pkg::SLOPE_MAX);
    end else if (ext < $signed(CW'(lhs_pkg::SLOPE_MIN))) begin
      slope_d = lhs_pkg::SLOPE_W'(lhs_pkg::SLOPE_MIN);
    end else begin
      slope_d = ext[lhs_pkg::SLOPE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      slope_q <= slope_d;
      undef_q <= undef_d;
    end
  end

  assign in_stall_o  = !en1;
  assign out_valid_o = v4_q;
  assign slope_o     = slope_q;
  assign undefined_o = undef_q;

endmodule

>>> rtl/lhs_checker.sv
// Port-level checks for local_hurst_slope_3x3, attached by bind.
// Depends on lhs_pkg for port widths.
`timescale 1ns / 1ps

module lhs_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [lhs_pkg::SLOPE_W-1:0]    slope_o,
  input logic                                  undefined_o
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // input is only held off by a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // undefined result carries a zero slope
  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && undefined_o |-> slope_o == '0)
    else $error("undefined result with nonzero slope");

  // with no output stall, an accepted transaction passes the input, range, table and result regs to out_valid_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_stall_i) ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

bind local_hurst_slope_3x3 lhs_checker u_lhs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .slope_o     (slope_o),
  .undefined_o (undefined_o)
);
